### design/navsup_pkg.sv
// Shared types, codes and distance helper for the navigation supervisor.
package navsup_pkg;

    // Input and configuration field widths
    localparam int POS_W   = 21;
    localparam int LIM_W   = 16;
    localparam int RPL_W   = 4;
    localparam int SQ_W    = 2 * POS_W + 1;
    localparam int LSQ_W   = 2 * LIM_W;
    localparam int CFG_A_W = 3;

    // Configuration register indexes
    localparam logic [CFG_A_W-1:0] CFG_GOAL_X        = 3'd0;
    localparam logic [CFG_A_W-1:0] CFG_GOAL_Y        = 3'd1;
    localparam logic [CFG_A_W-1:0] CFG_GOAL_TOL      = 3'd2;
    localparam logic [CFG_A_W-1:0] CFG_PROGRESS_DIST = 3'd3;
    localparam logic [CFG_A_W-1:0] CFG_STUCK_LIMIT   = 3'd4;
    localparam logic [CFG_A_W-1:0] CFG_TIMEOUT_LIMIT = 3'd5;
    localparam logic [CFG_A_W-1:0] CFG_MAX_REPLANS   = 3'd6;

    // Function codes of an input word
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    // Reported phase codes
    localparam logic [2:0] PHASE_IDLE   = 3'd0;
    localparam logic [2:0] PHASE_PLAN   = 3'd1;
    localparam logic [2:0] PHASE_FOLLOW = 3'd2;
    localparam logic [2:0] PHASE_DONE   = 3'd3;
    localparam logic [2:0] PHASE_FAILED = 3'd4;

    // Failure causes
    localparam logic [1:0] CAUSE_NONE    = 2'd0;
    localparam logic [1:0] CAUSE_BUMPER  = 2'd1;
    localparam logic [1:0] CAUSE_STUCK   = 2'd2;
    localparam logic [1:0] CAUSE_TIMEOUT = 2'd3;

    // Reset values of the configuration registers
    localparam logic [LIM_W-1:0] RST_GOAL_TOL      = 16'd100;
    localparam logic [LIM_W-1:0] RST_PROGRESS_DIST = 16'd20;
    localparam logic [LIM_W-1:0] RST_STUCK_LIMIT   = 16'd250;
    localparam logic [LIM_W-1:0] RST_TIMEOUT_LIMIT = 16'd2000;
    localparam logic [RPL_W-1:0] RST_MAX_REPLANS   = 4'd3;

    typedef struct packed {
        logic                    func;
        logic signed [POS_W-1:0] pose_x;
        logic signed [POS_W-1:0] pose_y;
        logic                    bumper_hit;
        logic                    tracking_active;
    } item_t;

    // Limits seen by the control stage, squares already registered
    typedef struct packed {
        logic [LSQ_W-1:0] tol_sq;
        logic [LSQ_W-1:0] pd_sq;
        logic [LIM_W-1:0] stuck_limit;
        logic [LIM_W-1:0] timeout_limit;
        logic [RPL_W-1:0] max_replans;
    } limits_t;

    typedef struct packed {
        logic [RPL_W-1:0] replan_count;
        logic [1:0]       fail_cause;
        logic             success;
        logic             finished;
        logic             clear_bumper;
        logic             clear_path;
        logic             drive_follow;
        logic             drive_stop;
        logic             request_plan;
        logic [2:0]       phase;
    } result_t;

    // Exact squared distance between two points
    function automatic logic [SQ_W-1:0] sq_dist(
        input logic signed [POS_W-1:0] ax,
        input logic signed [POS_W-1:0] ay,
        input logic signed [POS_W-1:0] bx,
        input logic signed [POS_W-1:0] by
    );
        logic signed [POS_W:0]   dx;
        logic signed [POS_W:0]   dy;
        logic signed [POS_W:0]   ndx;
        logic signed [POS_W:0]   ndy;
        logic [POS_W-1:0]        ux;
        logic [POS_W-1:0]        uy;
        logic [2*POS_W-1:0]      sx;
        logic [2*POS_W-1:0]      sy;
        dx  = {ax[POS_W-1], ax} - {bx[POS_W-1], bx};
        dy  = {ay[POS_W-1], ay} - {by[POS_W-1], by};
        ndx = -dx;
        ndy = -dy;
        ux  = dx[POS_W] ? ndx[POS_W-1:0] : dx[POS_W-1:0];
        uy  = dy[POS_W] ? ndy[POS_W-1:0] : dy[POS_W-1:0];
        sx  = (2*POS_W)'(ux) * (2*POS_W)'(ux);
        sy  = (2*POS_W)'(uy) * (2*POS_W)'(uy);
        return {1'b0, sx} + {1'b0, sy};
    endfunction

endpackage

### design/navsup_dist.sv
// Distance stage: squared goal distance and squared movement from the progress reference.
module navsup_dist (
    input  navsup_pkg::item_t                          item,
    input  logic signed [navsup_pkg::POS_W-1:0]        goal_x,
    input  logic signed [navsup_pkg::POS_W-1:0]        goal_y,
    input  logic signed [navsup_pkg::POS_W-1:0]        ref_x,
    input  logic signed [navsup_pkg::POS_W-1:0]        ref_y,
    input  logic signed [navsup_pkg::POS_W-1:0]        fwd_x,
    input  logic signed [navsup_pkg::POS_W-1:0]        fwd_y,
    output logic [navsup_pkg::SQ_W-1:0]                goal_sq,
    output logic [navsup_pkg::SQ_W-1:0]                prog_sq_ref,
    output logic [navsup_pkg::SQ_W-1:0]                prog_sq_fwd
);

    // Goal distance against the configured goal
    assign goal_sq = navsup_pkg::sq_dist(goal_x, goal_y, item.pose_x, item.pose_y);

    // Movement against the stored reference, and against the word ahead
    // in case that word moves the reference to its own pose
    assign prog_sq_ref = navsup_pkg::sq_dist(item.pose_x, item.pose_y, ref_x, ref_y);
    assign prog_sq_fwd = navsup_pkg::sq_dist(item.pose_x, item.pose_y, fwd_x, fwd_y);

endmodule

### design/navsup_ctrl.sv
// Control stage: run state machine, counters and the result register.
module navsup_ctrl (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 step,
    input  navsup_pkg::item_t                    item,
    input  logic [navsup_pkg::SQ_W-1:0]          goal_sq,
    input  logic [navsup_pkg::SQ_W-1:0]          prog_sq,
    input  navsup_pkg::limits_t                  lim,
    output logic                                 set_ref,
    output logic signed [navsup_pkg::POS_W-1:0]  ref_x,
    output logic signed [navsup_pkg::POS_W-1:0]  ref_y,
    output navsup_pkg::result_t                  res
);

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_PLAN   = 5'b00010,
        PH_FOLLOW = 5'b00100,
        PH_DONE   = 5'b01000,
        PH_FAILED = 5'b10000
    } phase_t;

    localparam int LW = navsup_pkg::LIM_W;
    localparam int RW = navsup_pkg::RPL_W;
    localparam int SW = navsup_pkg::SQ_W;
    localparam logic [LW-1:0] CNT_MAX = {LW{1'b1}};

    phase_t                              phase_reg, phase_next;
    logic [LW-1:0]                       timeout_reg, timeout_next;
    logic [LW-1:0]                       stall_reg, stall_next;
    logic [RW-1:0]                       replans_reg, replans_next;
    logic [1:0]                          cause_reg, cause_next;
    logic signed [navsup_pkg::POS_W-1:0] ref_x_reg, ref_x_next;
    logic signed [navsup_pkg::POS_W-1:0] ref_y_reg, ref_y_next;
    navsup_pkg::result_t                 res_reg, res_next;

    logic          req, stop, follow, clrp, clrb, fin, succ, failed;
    logic [LW-1:0] stall_inc, timeout_inc;
    logic [2:0]    phase_code;

    assign ref_x = ref_x_reg;
    assign ref_y = ref_y_reg;
    assign res   = res_reg;

    // Saturating counter increments
    assign stall_inc   = (stall_reg == CNT_MAX) ? stall_reg : stall_reg + 1'b1;
    assign timeout_inc = (timeout_reg == CNT_MAX) ? timeout_reg : timeout_reg + 1'b1;

    // Decision for the word in this stage
    always_comb begin
        phase_next   = phase_reg;
        timeout_next = timeout_reg;
        stall_next   = stall_reg;
        replans_next = replans_reg;
        cause_next   = cause_reg;
        ref_x_next   = ref_x_reg;
        ref_y_next   = ref_y_reg;
        set_ref      = 1'b0;
        req          = 1'b0;
        stop         = 1'b0;
        follow       = 1'b0;
        clrp         = 1'b0;
        clrb         = 1'b0;
        fin          = 1'b0;
        succ         = 1'b0;
        failed       = 1'b0;
        if (item.func == navsup_pkg::FUNC_START) begin
            ref_x_next   = item.pose_x;
            ref_y_next   = item.pose_y;
            set_ref      = 1'b1;
            timeout_next = '0;
            stall_next   = '0;
            replans_next = '0;
            cause_next   = navsup_pkg::CAUSE_NONE;
            phase_next   = PH_PLAN;
        end else begin
            case (phase_reg)
                PH_PLAN: begin
                    req        = 1'b1;
                    phase_next = PH_FOLLOW;
                end
                PH_FOLLOW: begin
                    if (goal_sq < SW'(lim.tol_sq)) begin
                        stop       = 1'b1;
                        clrp       = 1'b1;
                        cause_next = navsup_pkg::CAUSE_NONE;
                        phase_next = PH_DONE;
                    end else if (item.bumper_hit) begin
                        stop = 1'b1;
                        clrb = 1'b1;
                        if (replans_reg < lim.max_replans) begin
                            replans_next = replans_reg + 1'b1;
                            phase_next   = PH_PLAN;
                        end else begin
                            clrp       = 1'b1;
                            cause_next = navsup_pkg::CAUSE_BUMPER;
                            phase_next = PH_FAILED;
                        end
                    end else if (!item.tracking_active) begin
                        stop       = 1'b1;
                        clrp       = 1'b1;
                        cause_next = navsup_pkg::CAUSE_NONE;
                        phase_next = PH_DONE;
                    end else begin
                        follow = 1'b1;
                        // progress check, then stall and global timeout
                        if (prog_sq > SW'(lim.pd_sq)) begin
                            stall_next = '0;
                            ref_x_next = item.pose_x;
                            ref_y_next = item.pose_y;
                            set_ref    = 1'b1;
                        end else begin
                            stall_next = stall_inc;
                            if (stall_inc >= lim.stuck_limit) begin
                                failed     = 1'b1;
                                cause_next = navsup_pkg::CAUSE_STUCK;
                            end
                        end
                        if (!failed) begin
                            timeout_next = timeout_inc;
                            if (timeout_inc >= lim.timeout_limit) begin
                                failed     = 1'b1;
                                cause_next = navsup_pkg::CAUSE_TIMEOUT;
                            end
                        end
                        if (failed) begin
                            follow     = 1'b0;
                            stop       = 1'b1;
                            clrp       = 1'b1;
                            phase_next = PH_FAILED;
                        end
                    end
                end
                PH_DONE, PH_FAILED: begin
                    fin        = 1'b1;
                    stop       = 1'b1;
                    clrp       = 1'b1;
                    succ       = (phase_reg == PH_DONE);
                    phase_next = PH_IDLE;
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Phase as reported
    always_comb begin
        case (phase_next)
            PH_PLAN:   phase_code = navsup_pkg::PHASE_PLAN;
            PH_FOLLOW: phase_code = navsup_pkg::PHASE_FOLLOW;
            PH_DONE:   phase_code = navsup_pkg::PHASE_DONE;
            PH_FAILED: phase_code = navsup_pkg::PHASE_FAILED;
            default:   phase_code = navsup_pkg::PHASE_IDLE;
        endcase
    end

    always_comb begin
        res_next.phase        = phase_code;
        res_next.request_plan = req;
        res_next.drive_stop   = stop;
        res_next.drive_follow = follow;
        res_next.clear_path   = clrp;
        res_next.clear_bumper = clrb;
        res_next.finished     = fin;
        res_next.success      = succ;
        res_next.fail_cause   = cause_next;
        res_next.replan_count = replans_next;
    end

    // Run state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            timeout_reg <= '0;
            stall_reg   <= '0;
            replans_reg <= '0;
            cause_reg   <= navsup_pkg::CAUSE_NONE;
            ref_x_reg   <= '0;
            ref_y_reg   <= '0;
        end else if (step) begin
            phase_reg   <= phase_next;
            timeout_reg <= timeout_next;
            stall_reg   <= stall_next;
            replans_reg <= replans_next;
            cause_reg   <= cause_next;
            ref_x_reg   <= ref_x_next;
            ref_y_reg   <= ref_y_next;
        end
    end

    // Result word
    always_ff @(posedge aclk) begin
        if (step) begin
            res_reg <= res_next;
        end
    end

    // A reported outcome always leaves the block idle
    a_report_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        step && fin |=> phase_reg == PH_IDLE)
        else $error("report tick did not return to idle");

    // A plan request always moves on to follow
    a_plan_follow: assert property (@(posedge aclk) disable iff (!aresetn)
        step && req |=> phase_reg == PH_FOLLOW)
        else $error("plan request without follow");

    // A start clears every counter of the run
    a_start_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        step && item.func == navsup_pkg::FUNC_START |=>
            stall_reg == '0 && timeout_reg == '0 && replans_reg == '0)
        else $error("start did not clear the run counters");

endmodule

### design/navigation_supervisor_fsm_core.sv
// Top level of the navigation supervisor: ports, configuration and pipeline control.
//
//  channel   ports              dir  contents
//  s_        tvalid/tready      in   pose, bumper and tracking word; tuser = start or tick
//  m_        tvalid/tready      out  phase, drive flags, outcome, replan count
//  cfg_      we/addr/wdata      in   register writes, seven registers, no read-back
//
//  Three register stages: input word, squared distances, result. m_tvalid rises once
//  a word has reached the result register; one word per cycle while m_tready stays high.
//  Movement distance is forwarded from the word ahead, so back-to-back ticks see the
//  reference it leaves. aresetn is synchronous and active low; it restores the
//  configuration defaults and an idle run. Each stage holds while the one after it is
//  full and stalled; s_tready stays high while any stage has room.
module navigation_supervisor_fsm_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // pose_x[20:0], pose_y[41:21], bumper_hit[42], tracking_active[43], zero fill
    input  logic [47:0]                          s_tdata,
    // func[0]
    input  logic [0:0]                           s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // phase[2:0], request_plan[3], drive_stop[4], drive_follow[5], clear_path[6],
    // clear_bumper[7], finished[8], success[9], fail_cause[11:10], replan_count[15:12]
    output logic [15:0]                          m_tdata,
    input  logic                                 cfg_we,
    input  logic [navsup_pkg::CFG_A_W-1:0]       cfg_addr,
    input  logic [navsup_pkg::POS_W-1:0]         cfg_wdata
);

    localparam int PW = navsup_pkg::POS_W;
    localparam int LW = navsup_pkg::LIM_W;
    localparam int RW = navsup_pkg::RPL_W;
    localparam int SW = navsup_pkg::SQ_W;
    localparam int QW = navsup_pkg::LSQ_W;

    // Configuration registers
    logic signed [PW-1:0] goal_x_reg, goal_y_reg;
    logic [LW-1:0]        tol_reg, pd_reg, stuck_reg, timeout_lim_reg;
    logic [RW-1:0]        max_replans_reg;
    logic [QW-1:0]        tol_sq_reg, pd_sq_reg;

    // Pipeline registers
    logic                 r_valid_reg, m_valid_reg, out_valid_reg;
    navsup_pkg::item_t    r_item_reg, m_item_reg, s_item;
    logic [SW-1:0]        m_goal_sq_reg, m_prog_sq_reg;

    logic                 out_ready, m_step, m_load, r_adv, s_accept;
    logic                 set_ref;
    logic signed [PW-1:0] ref_x, ref_y;
    logic [SW-1:0]        goal_sq, prog_sq_ref, prog_sq_fwd;
    navsup_pkg::limits_t  lim;
    navsup_pkg::result_t  res;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            goal_x_reg      <= '0;
            goal_y_reg      <= '0;
            tol_reg         <= navsup_pkg::RST_GOAL_TOL;
            pd_reg          <= navsup_pkg::RST_PROGRESS_DIST;
            stuck_reg       <= navsup_pkg::RST_STUCK_LIMIT;
            timeout_lim_reg <= navsup_pkg::RST_TIMEOUT_LIMIT;
            max_replans_reg <= navsup_pkg::RST_MAX_REPLANS;
        end else if (cfg_we) begin
            case (cfg_addr)
                navsup_pkg::CFG_GOAL_X:        goal_x_reg      <= cfg_wdata;
                navsup_pkg::CFG_GOAL_Y:        goal_y_reg      <= cfg_wdata;
                navsup_pkg::CFG_GOAL_TOL:      tol_reg         <= cfg_wdata[LW-1:0];
                navsup_pkg::CFG_PROGRESS_DIST: pd_reg          <= cfg_wdata[LW-1:0];
                navsup_pkg::CFG_STUCK_LIMIT:   stuck_reg       <= cfg_wdata[LW-1:0];
                navsup_pkg::CFG_TIMEOUT_LIMIT: timeout_lim_reg <= cfg_wdata[LW-1:0];
                navsup_pkg::CFG_MAX_REPLANS:   max_replans_reg <= cfg_wdata[RW-1:0];
                default: ;
            endcase
        end
    end

    // Squared radii, registered from the radius registers and so updated the cycle after them
    always_ff @(posedge aclk) begin
        tol_sq_reg <= QW'(tol_reg) * QW'(tol_reg);
        pd_sq_reg  <= QW'(pd_reg) * QW'(pd_reg);
    end

    assign lim.tol_sq        = tol_sq_reg;
    assign lim.pd_sq         = pd_sq_reg;
    assign lim.stuck_limit   = stuck_reg;
    assign lim.timeout_limit = timeout_lim_reg;
    assign lim.max_replans   = max_replans_reg;

    // Stage handshakes
    assign out_ready = !out_valid_reg || m_tready;
    assign m_step    = m_valid_reg && out_ready;
    assign m_load    = !m_valid_reg || out_ready;
    assign r_adv     = r_valid_reg && m_load;
    assign s_tready  = !r_valid_reg || m_load;
    assign s_accept  = s_tvalid && s_tready;

    assign s_item.func            = s_tuser[0];
    assign s_item.pose_x          = s_tdata[PW-1:0];
    assign s_item.pose_y          = s_tdata[2*PW-1:PW];
    assign s_item.bumper_hit      = s_tdata[2*PW];
    assign s_item.tracking_active = s_tdata[2*PW+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                r_valid_reg <= s_tvalid;
            end
            if (m_load) begin
                m_valid_reg <= r_valid_reg;
            end
            if (m_step) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Input word register
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            r_item_reg <= s_item;
        end
    end

    navsup_dist u_dist (
        .item        (r_item_reg),
        .goal_x      (goal_x_reg),
        .goal_y      (goal_y_reg),
        .ref_x       (ref_x),
        .ref_y       (ref_y),
        .fwd_x       (m_item_reg.pose_x),
        .fwd_y       (m_item_reg.pose_y),
        .goal_sq     (goal_sq),
        .prog_sq_ref (prog_sq_ref),
        .prog_sq_fwd (prog_sq_fwd)
    );

    // Distance register; take the forwarded distance when the word ahead
    // moves the reference on this same edge
    always_ff @(posedge aclk) begin
        if (r_adv) begin
            m_item_reg    <= r_item_reg;
            m_goal_sq_reg <= goal_sq;
            m_prog_sq_reg <= (m_step && set_ref) ? prog_sq_fwd : prog_sq_ref;
        end
    end

    navsup_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (m_step),
        .item    (m_item_reg),
        .goal_sq (m_goal_sq_reg),
        .prog_sq (m_prog_sq_reg),
        .lim     (lim),
        .set_ref (set_ref),
        .ref_x   (ref_x),
        .ref_y   (ref_y),
        .res     (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = res;

endmodule

### tb/sv/navigation_supervisor_fsm_core_tb.sv
// Self-checking testbench for the navigation supervisor core: directed and random runs.
`timescale 1ns / 100ps

module navigation_supervisor_fsm_core_tb;

    localparam int POS_W   = navsup_pkg::POS_W;
    localparam int LIM_W   = navsup_pkg::LIM_W;
    localparam int RPL_W   = navsup_pkg::RPL_W;
    localparam int CFG_A_W = navsup_pkg::CFG_A_W;
    localparam int POS_MAX = 1048575;
    localparam int POS_MIN = -1048576;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [47:0]          s_tdata;
    logic [0:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [15:0]          m_tdata;
    logic                 cfg_we;
    logic [CFG_A_W-1:0]   cfg_addr;
    logic [POS_W-1:0]     cfg_wdata;

    // Supervisor copy: configuration
    logic signed [POS_W-1:0] goal_x_r;
    logic signed [POS_W-1:0] goal_y_r;
    logic [LIM_W-1:0]        tol_r;
    logic [LIM_W-1:0]        progress_r;
    logic [LIM_W-1:0]        stuck_r;
    logic [LIM_W-1:0]        timeout_r;
    logic [RPL_W-1:0]        replans_max_r;

    // Supervisor copy: run state
    logic [2:0]              sup_phase;
    logic [LIM_W-1:0]        timeout_ticks;
    logic [LIM_W-1:0]        stall_ticks;
    logic [RPL_W-1:0]        replans_used;
    logic signed [POS_W-1:0] anchor_x;
    logic signed [POS_W-1:0] anchor_y;
    logic [1:0]              cause_r;

    navsup_pkg::result_t pending_results[$];

    int  mismatches    = 0;
    int  words_sent    = 0;
    int  results_seen  = 0;
    int  runs_reached  = 0;
    int  runs_failed   = 0;
    int  cfg_settings  = 0;
    int  idle_div      = 4;   // 0 disables idling on both sides

    navigation_supervisor_fsm_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Squared distance, exact in 64 bits
    function automatic longint dist_sq(longint ax, longint ay, longint bx, longint by);
        longint dx;
        longint dy;
        dx = ax - bx;
        dy = ay - by;
        return dx * dx + dy * dy;
    endfunction

    function automatic int clip_pos(int v);
        if (v > POS_MAX) return POS_MAX;
        if (v < POS_MIN) return POS_MIN;
        return v;
    endfunction

    function automatic int rand_pos();
        return int'($urandom_range(0, 21'h1FFFFF)) + POS_MIN;
    endfunction

    // Advance the supervisor copy by one word, return the word it reports
    function automatic navsup_pkg::result_t advance_supervisor(navsup_pkg::item_t w);
        navsup_pkg::result_t r;
        logic                failed;
        longint              tol_sq;
        longint              pd_sq;
        r      = '0;
        failed = 1'b0;
        tol_sq = longint'(tol_r) * longint'(tol_r);
        pd_sq  = longint'(progress_r) * longint'(progress_r);
        if (w.func == navsup_pkg::FUNC_START) begin
            anchor_x      = w.pose_x;
            anchor_y      = w.pose_y;
            timeout_ticks = '0;
            stall_ticks   = '0;
            replans_used  = '0;
            cause_r       = navsup_pkg::CAUSE_NONE;
            sup_phase     = navsup_pkg::PHASE_PLAN;
        end else begin
            case (sup_phase)
                navsup_pkg::PHASE_PLAN: begin
                    r.request_plan = 1'b1;
                    sup_phase      = navsup_pkg::PHASE_FOLLOW;
                end
                navsup_pkg::PHASE_FOLLOW: begin
                    if (dist_sq(goal_x_r, goal_y_r, w.pose_x, w.pose_y) < tol_sq) begin
                        r.drive_stop = 1'b1;
                        r.clear_path = 1'b1;
                        cause_r      = navsup_pkg::CAUSE_NONE;
                        sup_phase    = navsup_pkg::PHASE_DONE;
                    end else if (w.bumper_hit) begin
                        r.drive_stop   = 1'b1;
                        r.clear_bumper = 1'b1;
                        if (replans_used < replans_max_r) begin
                            replans_used = replans_used + 1'b1;
                            sup_phase    = navsup_pkg::PHASE_PLAN;
                        end else begin
                            r.clear_path = 1'b1;
                            cause_r      = navsup_pkg::CAUSE_BUMPER;
                            sup_phase    = navsup_pkg::PHASE_FAILED;
                        end
                    end else if (!w.tracking_active) begin
                        // end of path counts as arrival
                        r.drive_stop = 1'b1;
                        r.clear_path = 1'b1;
                        cause_r      = navsup_pkg::CAUSE_NONE;
                        sup_phase    = navsup_pkg::PHASE_DONE;
                    end else begin
                        r.drive_follow = 1'b1;
                        if (dist_sq(w.pose_x, w.pose_y, anchor_x, anchor_y) > pd_sq) begin
                            stall_ticks = '0;
                            anchor_x    = w.pose_x;
                            anchor_y    = w.pose_y;
                        end else begin
                            if (stall_ticks != 16'hFFFF) stall_ticks = stall_ticks + 1'b1;
                            if (stall_ticks >= stuck_r) begin
                                failed  = 1'b1;
                                cause_r = navsup_pkg::CAUSE_STUCK;
                            end
                        end
                        if (!failed) begin
                            if (timeout_ticks != 16'hFFFF) timeout_ticks = timeout_ticks + 1'b1;
                            if (timeout_ticks >= timeout_r) begin
                                failed  = 1'b1;
                                cause_r = navsup_pkg::CAUSE_TIMEOUT;
                            end
                        end
                        if (failed) begin
                            r.drive_follow = 1'b0;
                            r.drive_stop   = 1'b1;
                            r.clear_path   = 1'b1;
                            sup_phase      = navsup_pkg::PHASE_FAILED;
                        end
                    end
                end
                navsup_pkg::PHASE_DONE, navsup_pkg::PHASE_FAILED: begin
                    // outcome report, counters kept
                    r.finished   = 1'b1;
                    r.drive_stop = 1'b1;
                    r.clear_path = 1'b1;
                    r.success    = (sup_phase == navsup_pkg::PHASE_DONE);
                    if (sup_phase == navsup_pkg::PHASE_DONE) runs_reached++;
                    else runs_failed++;
                    sup_phase = navsup_pkg::PHASE_IDLE;
                end
                default: sup_phase = navsup_pkg::PHASE_IDLE;
            endcase
        end
        r.phase        = sup_phase;
        r.fail_cause   = cause_r;
        r.replan_count = replans_used;
        return r;
    endfunction

    task automatic report_mismatch(string field, int got, int exp);
        $display("MISMATCH result %0d %s: got %0d expected %0d", results_seen, field, got, exp);
        mismatches++;
    endtask

    task automatic compare_result(navsup_pkg::result_t got, navsup_pkg::result_t exp);
        if (got.phase != exp.phase)
            report_mismatch("phase", got.phase, exp.phase);
        if (got.request_plan != exp.request_plan)
            report_mismatch("request_plan", got.request_plan, exp.request_plan);
        if (got.drive_stop != exp.drive_stop)
            report_mismatch("drive_stop", got.drive_stop, exp.drive_stop);
        if (got.drive_follow != exp.drive_follow)
            report_mismatch("drive_follow", got.drive_follow, exp.drive_follow);
        if (got.clear_path != exp.clear_path)
            report_mismatch("clear_path", got.clear_path, exp.clear_path);
        if (got.clear_bumper != exp.clear_bumper)
            report_mismatch("clear_bumper", got.clear_bumper, exp.clear_bumper);
        if (got.finished != exp.finished)
            report_mismatch("finished", got.finished, exp.finished);
        if (got.success != exp.success)
            report_mismatch("success", got.success, exp.success);
        if (got.fail_cause != exp.fail_cause)
            report_mismatch("fail_cause", got.fail_cause, exp.fail_cause);
        if (got.replan_count != exp.replan_count)
            report_mismatch("replan_count", got.replan_count, exp.replan_count);
    endtask

    // Result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                // word with nothing outstanding
                report_mismatch("unexpected word", 1, 0);
            end else begin
                compare_result(navsup_pkg::result_t'(m_tdata), pending_results.pop_front());
            end
            results_seen++;
        end
    end

    // Result side back-pressure
    initial begin
        @(posedge aclk iff aresetn);
        forever begin
            @(posedge aclk);
            if (idle_div != 0 && $urandom_range(0, idle_div - 1) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // Send one word, predict its result once accepted
    task automatic send_word(logic func, int px, int py, logic bump, logic track);
        navsup_pkg::item_t w;
        w.func            = func;
        w.pose_x          = px[POS_W-1:0];
        w.pose_y          = py[POS_W-1:0];
        w.bumper_hit      = bump;
        w.tracking_active = track;
        if (idle_div != 0 && $urandom_range(0, idle_div - 1) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= w.func;
        s_tdata  <= {4'b0, w.tracking_active, w.bumper_hit, w.pose_y, w.pose_x};
        do @(posedge aclk); while (!s_tready);
        pending_results.insert(pending_results.size(), advance_supervisor(w));
        words_sent++;
    endtask

    // Stop sending and let every outstanding result come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_A_W-1:0] idx, logic [POS_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            navsup_pkg::CFG_GOAL_X:        goal_x_r      = value;
            navsup_pkg::CFG_GOAL_Y:        goal_y_r      = value;
            navsup_pkg::CFG_GOAL_TOL:      tol_r         = value[LIM_W-1:0];
            navsup_pkg::CFG_PROGRESS_DIST: progress_r    = value[LIM_W-1:0];
            navsup_pkg::CFG_STUCK_LIMIT:   stuck_r       = value[LIM_W-1:0];
            navsup_pkg::CFG_TIMEOUT_LIMIT: timeout_r     = value[LIM_W-1:0];
            navsup_pkg::CFG_MAX_REPLANS:   replans_max_r = value[RPL_W-1:0];
            default: ;
        endcase
    endtask

    // Full register set, written with the pipeline empty
    task automatic set_limits(int gx, int gy, int tol, int pd, int stuck, int tmo, int rpl);
        drain();
        write_reg(navsup_pkg::CFG_GOAL_X,        gx[POS_W-1:0]);
        write_reg(navsup_pkg::CFG_GOAL_Y,        gy[POS_W-1:0]);
        write_reg(navsup_pkg::CFG_GOAL_TOL,      POS_W'(tol[LIM_W-1:0]));
        write_reg(navsup_pkg::CFG_PROGRESS_DIST, POS_W'(pd[LIM_W-1:0]));
        write_reg(navsup_pkg::CFG_STUCK_LIMIT,   POS_W'(stuck[LIM_W-1:0]));
        write_reg(navsup_pkg::CFG_TIMEOUT_LIMIT, POS_W'(tmo[LIM_W-1:0]));
        write_reg(navsup_pkg::CFG_MAX_REPLANS,   POS_W'(rpl[RPL_W-1:0]));
        cfg_we <= 1'b0;
        // squared limits are registered inside
        repeat (4) @(posedge aclk);
        cfg_settings++;
    endtask

    // Reset defaults: idle tick, replan, restart mid-run, tolerance edge, arrival
    task automatic test_default_run();
        send_word(navsup_pkg::FUNC_TICK,  POS_MIN, POS_MAX, 1'b1, 1'b0);
        send_word(navsup_pkg::FUNC_START, POS_MAX, POS_MIN, 1'b1, 1'b0);
        send_word(navsup_pkg::FUNC_TICK,  POS_MAX, POS_MIN, 1'b0, 1'b1);
        send_word(navsup_pkg::FUNC_TICK,  POS_MAX, POS_MIN, 1'b0, 1'b1);
        send_word(navsup_pkg::FUNC_TICK,  POS_MAX, POS_MIN, 1'b1, 1'b1);
        send_word(navsup_pkg::FUNC_TICK,  -1, -1, 1'b0, 1'b1);
        send_word(navsup_pkg::FUNC_START, 0, 500, 1'b0, 1'b1);
        send_word(navsup_pkg::FUNC_TICK,  0, 500, 1'b0, 1'b1);
        send_word(navsup_pkg::FUNC_TICK,  60, 80, 1'b0, 1'b1);
        send_word(navsup_pkg::FUNC_TICK,  50, 50, 1'b1, 1'b0);
        send_word(navsup_pkg::FUNC_TICK,  0, 0, 1'b0, 1'b1);
    endtask

    // Path end, bumper limit, stuck and timeout with zero limits
    task automatic test_run_endings();
        send_word(navsup_pkg::FUNC_START, POS_MIN, POS_MAX, 1'b0, 1'b1);
        send_word(navsup_pkg::FUNC_TICK,  POS_MIN, POS_MAX, 1'b0, 1'b1);
        send_word(navsup_pkg::FUNC_TICK,  POS_MIN, POS_MAX, 1'b0, 1'b0);
        send_word(navsup_pkg::FUNC_TICK,  POS_MIN, POS_MAX, 1'b0, 1'b1);
        set_limits(0, 0, 100, 20, 0, 2000, 0);
        send_word(navsup_pkg::FUNC_START, 300000, 0, 1'b0, 1'b1);
        send_word(navsup_pkg::FUNC_TICK,  300000, 0, 1'b0, 1'b1);
        send_word(navsup_pkg::FUNC_TICK,  300000, 0, 1'b1, 1'b1);
        send_word(navsup_pkg::FUNC_TICK,  300000, 0, 1'b0, 1'b1);
        send_word(navsup_pkg::FUNC_START, 300000, 0, 1'b0, 1'b1);
        send_word(navsup_pkg::FUNC_TICK,  300000, 0, 1'b0, 1'b1);
        send_word(navsup_pkg::FUNC_TICK,  400000, 0, 1'b0, 1'b1);
        send_word(navsup_pkg::FUNC_TICK,  400000, 0, 1'b0, 1'b1);
        send_word(navsup_pkg::FUNC_TICK,  400000, 0, 1'b0, 1'b1);
        set_limits(0, 0, 100, 20, 250, 0, 15);
        send_word(navsup_pkg::FUNC_START, -300000, 0, 1'b0, 1'b1);
        send_word(navsup_pkg::FUNC_TICK,  -300000, 0, 1'b0, 1'b1);
        send_word(navsup_pkg::FUNC_TICK,  -200000, 0, 1'b0, 1'b1);
        send_word(navsup_pkg::FUNC_TICK,  -200000, 0, 1'b0, 1'b1);
    endtask

    // Random settings, then mostly well-formed runs with random motion
    task automatic test_random_runs(int n_words);
        int gx, gy, tol, pd, stuck, tmo;
        int x, y, span, cap, k, pick, count;
        logic func;
        gx    = ($urandom_range(0, 4) == 0) ? (($urandom_range(0, 1) != 0) ? POS_MAX : POS_MIN)
                                            : rand_pos();
        gy    = ($urandom_range(0, 4) == 0) ? (($urandom_range(0, 1) != 0) ? POS_MAX : POS_MIN)
                                            : rand_pos();
        pick  = $urandom_range(0, 9);
        tol   = (pick == 0) ? 0 : (pick == 1) ? 65535 : $urandom_range(50, 3000);
        pick  = $urandom_range(0, 9);
        pd    = (pick == 0) ? 0 : (pick == 1) ? 65535 : $urandom_range(1, 300);
        pick  = $urandom_range(0, 9);
        stuck = (pick == 0) ? 65535 : (pick == 1) ? 1 : $urandom_range(2, 40);
        pick  = $urandom_range(0, 9);
        tmo   = (pick == 0) ? 65535 : (pick == 1) ? 1 : $urandom_range(5, 300);
        set_limits(gx, gy, tol, pd, stuck, tmo, $urandom_range(0, 15));
        count = 0;
        while (count < n_words) begin
            if ($urandom_range(0, 9) == 0) begin
                // noise word, any field values
                func = 1'($urandom_range(0, 1));
                if (func == navsup_pkg::FUNC_START || sup_phase != navsup_pkg::PHASE_IDLE)
                    count++;
                send_word(func, rand_pos(), rand_pos(), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            end else begin
                x = clip_pos(gx + int'($urandom_range(0, 40000)) - 20000);
                y = clip_pos(gy + int'($urandom_range(0, 40000)) - 20000);
                send_word(navsup_pkg::FUNC_START, x, y, 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
                cap = $urandom_range(5, 120);
                k   = 0;
                while (sup_phase != navsup_pkg::PHASE_IDLE && k < cap) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 35) begin
                        x = x + (gx - x) / 3;
                        y = y + (gy - y) / 3;
                    end else if (pick < 70) begin
                        span = 2 * pd + 8;
                        x = clip_pos(x + int'($urandom_range(0, span)) - span / 2);
                        y = clip_pos(y + int'($urandom_range(0, span)) - span / 2);
                    end
                    send_word(navsup_pkg::FUNC_TICK, x, y, $urandom_range(0, 24) == 0,
                              $urandom_range(0, 39) != 0);
                    k++;
                end
                count += k + 1;
            end
        end
    endtask

    // Global timeout with progress on every tick and the stall limit at full scale
    task automatic test_counter_limits();
        int k;
        set_limits(0, 0, 0, 0, 65535, 60, 15);
        send_word(navsup_pkg::FUNC_START, 600000, 600000, 1'b0, 1'b1);
        k = 0;
        while (sup_phase != navsup_pkg::PHASE_IDLE) begin
            send_word(navsup_pkg::FUNC_TICK, 600000 + (k & 1), 600000, 1'b0, 1'b1);
            k++;
        end
    endtask

    // Main sequence
    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        m_tready  <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= '0;
        goal_x_r      = '0;
        goal_y_r      = '0;
        tol_r         = navsup_pkg::RST_GOAL_TOL;
        progress_r    = navsup_pkg::RST_PROGRESS_DIST;
        stuck_r       = navsup_pkg::RST_STUCK_LIMIT;
        timeout_r     = navsup_pkg::RST_TIMEOUT_LIMIT;
        replans_max_r = navsup_pkg::RST_MAX_REPLANS;
        sup_phase     = navsup_pkg::PHASE_IDLE;
        timeout_ticks = '0;
        stall_ticks   = '0;
        replans_used  = '0;
        anchor_x      = '0;
        anchor_y      = '0;
        cause_r       = navsup_pkg::CAUSE_NONE;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_run();
        test_run_endings();
        for (int p = 0; p < 8; p++) begin
            // idling varies per phase, none in the last part
            idle_div = (p == 7) ? 0 : (p % 3 == 0) ? 0 : (p % 3 == 1) ? 3 : 10;
            test_random_runs(185);
        end
        test_counter_limits();

        drain();
        repeat (10) @(posedge aclk);
        $display("Sent %0d words, checked %0d results over %0d register settings",
                 words_sent, results_seen, cfg_settings);
        $display("Runs reported: %0d reached the goal, %0d failed", runs_reached, runs_failed);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #8_000_000;
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
